>>> hdl/ssi_pkg.sv
`default_nettype none

package ssi_pkg;

    localparam int KEY_W   = 32;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_SPARE  = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_ABSENT  = 2'd1,
        STAT_PRESENT = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_UPD
    } t_state;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic                    cmp;   // latch compare flags against key
        logic                    ins;   // shift right from insert point
        logic                    rem;   // shift left onto removed entry
        logic signed [KEY_W-1:0] key;
    } t_cmd;

    // Per-cell compare result, registered in the cell.
    typedef struct packed {
        logic lt;   // held key below request key
        logic eq;   // held key equals request key
    } t_flags;

endpackage

`default_nettype wire

>>> hdl/ssi_cell.sv
`default_nettype none

module ssi_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire logic                            i_clk,
    input  wire ssi_pkg::t_cmd                   i_cmd,
    input  wire logic [CNT_W-1:0]                i_occ,
    input  wire logic signed [ssi_pkg::KEY_W-1:0] i_left_key,
    input  wire logic                            i_left_lt,
    input  wire logic signed [ssi_pkg::KEY_W-1:0] i_right_key,
    output logic signed [ssi_pkg::KEY_W-1:0]     o_key,
    output ssi_pkg::t_flags                      o_flags
);
    import ssi_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    t_flags                  r_flags;
    t_flags                  n_flags;
    logic                    active;

    assign active = (CNT_W'(IDX) < i_occ);

    always_comb begin
        n_flags = r_flags;
        if (i_cmd.cmp) begin
            n_flags.lt = active && (r_key < i_cmd.key);
            n_flags.eq = active && (r_key == i_cmd.key);
        end
    end

    // Entries at or past the insert/remove point move by one place.
    always_comb begin
        n_key = r_key;
        if (i_cmd.ins && !r_flags.lt) begin
            n_key = i_left_lt ? i_cmd.key : i_left_key;
        end else if (i_cmd.rem && !r_flags.lt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_flags <= n_flags;
    end

    assign o_key   = r_key;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

>>> hdl/sorted_integer_set.sv
`default_nettype none

// Channel  | Dir | Signals                                  | Carries
// ---------+-----+------------------------------------------+----------------------------
// s (req)  | in  | i_s_tvalid o_s_tready i_s_tdata i_s_tuser | key, request type
// m (res)  | out | o_m_tvalid i_m_tready o_m_tdata o_m_tuser | member count, status
//
// A request is taken in the idle state: on the accept edge every cell compares its key with the
// request key; in the update state the found flags are combined, the row shifts by one place
// for an insert or a remove, and the result is loaded; no new request is accepted before
// then. The update cycle waits while the result register is still full and not taken.
// Reset (i_rst_n low, synchronous) empties the set; no clearing pass is needed.
// A result waiting downstream does not block acceptance of the next request.

module sorted_integer_set #(
    parameter int CAPACITY = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] key (signed)
    input  wire logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [6:0] member_count, [7] zero
    output logic [1:0]       o_m_tuser    // [1:0] status
);
    import ssi_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // control
    t_state         r_state;
    t_state         n_state;
    logic [CNT_W-1:0] r_occ;
    logic [CNT_W-1:0] n_occ;
    logic           r_out_valid;
    logic           n_out_valid;

    // payload
    t_req                    r_req;
    logic signed [KEY_W-1:0] r_req_key;
    t_status                 r_status;
    t_status                 n_status;
    logic [COUNT_W-1:0]      r_count;
    logic [COUNT_W-1:0]      n_count;

    logic accept;
    logic out_free;
    logic upd_go;
    logic found;
    logic full;
    logic do_ins;
    logic do_rem;
    t_cmd cmd;
    logic [CNT_W+COUNT_W-1:0] occ_ext;

    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    t_flags                  cell_flags [CAPACITY];

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign upd_go   = (r_state == ST_UPD) && out_free;
    assign full     = (r_occ == CNT_W'(CAPACITY));

    // any cell holding the key; sorted order makes at most one hit
    always_comb begin
        found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            found = found | cell_flags[i].eq;
        end
    end

    assign do_ins = upd_go && (r_req == REQ_INSERT) && !found && !full;
    assign do_rem = upd_go && (r_req == REQ_REMOVE) && found;

    always_comb begin
        cmd.cmp = accept;
        cmd.ins = do_ins;
        cmd.rem = do_rem;
        cmd.key = (r_state == ST_IDLE) ? $signed(i_s_tdata) : r_req_key;
    end

    // the row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] left_key;
        logic                    left_lt;
        logic signed [KEY_W-1:0] right_key;

        if (g == 0) begin : g_head
            assign left_key = cmd.key;
            assign left_lt  = 1'b1;
        end else begin : g_body
            assign left_key = cell_key[g-1];
            assign left_lt  = cell_flags[g-1].lt;
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_key = cell_key[g];
        end else begin : g_inner
            assign right_key = cell_key[g+1];
        end

        ssi_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_occ       (r_occ),
            .i_left_key  (left_key),
            .i_left_lt   (left_lt),
            .i_right_key (right_key),
            .o_key       (cell_key[g]),
            .o_flags     (cell_flags[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: o_s_tready = 1'b1;
            ST_UPD:  o_s_tready = 1'b0;
            default: o_s_tready = 1'b0;
        endcase
    end

    // status and count
    always_comb begin
        n_occ = r_occ;
        if (do_ins) n_occ = r_occ + CNT_W'(1);
        else if (do_rem) n_occ = r_occ - CNT_W'(1);

        case (r_req)
            REQ_INSERT: begin
                if (found)     n_status = STAT_PRESENT;
                else if (full) n_status = STAT_FULL;
                else           n_status = STAT_OK;
            end
            REQ_REMOVE: n_status = found ? STAT_OK : STAT_ABSENT;
            default:    n_status = found ? STAT_OK : STAT_ABSENT;
        endcase

        occ_ext = {{COUNT_W{1'b0}}, n_occ};
        n_count = occ_ext[COUNT_W-1:0];

        n_out_valid = r_out_valid;
        if (upd_go)          n_out_valid = 1'b1;
        else if (i_m_tready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= t_req'(i_s_tuser);
            r_req_key <= $signed(i_s_tdata);
        end
        if (upd_go) begin
            r_status <= n_status;
            r_count  <= n_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_count};
    assign o_m_tuser  = r_status;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == $past(r_occ)) || (r_occ == $past(r_occ) + CNT_W'(1)) ||
        (r_occ == $past(r_occ) - CNT_W'(1)))
        else $error("occupancy moved by more than one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("request accepted during update");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == STAT_FULL)) |-> full)
        else $error("full status with free room");

    a_no_update_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!do_ins && !do_rem))
        else $error("row shifted without a request");
`endif

endmodule

`default_nettype wire
